// File: sv/sal_pkg.sv
// Shared constants, codes and helpers for the set-associative LRU cache.
// No dependencies; every other file of the block imports this package.
package sal_pkg;

    // Default geometry
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;

    // Request kinds carried on s_tuser
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_STORE  = 2'd1;
    localparam logic [1:0] REQ_MODIFY = 2'd2;
    localparam logic [1:0] REQ_IGNORE = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 32;
    localparam int M_FIELD_W = 2 + 3 * CNT_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    // Outcome of one way scan
    typedef struct packed {
        logic hit;
        logic evict;
        logic no_limit;
    } sal_pick_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

// File: sv/sal_row_mem.sv
// Set row storage: valid, tag and age of every way, one row per set.
// Per-row live flags clear the whole cache at reset. Depends on sal_pkg.
module sal_row_mem import sal_pkg::*; #(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     rd_en,
    input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] rd_addr,
    input  logic                                     wr_en,
    input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] wr_addr,
    input  logic [MAX_WAYS-1:0]                      wr_valid,
    input  logic [MAX_WAYS-1:0][ADDR_W-1:0]          wr_tag,
    input  logic [MAX_WAYS-1:0][((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] wr_age,
    output logic [MAX_WAYS-1:0]                      rd_valid,
    output logic [MAX_WAYS-1:0][ADDR_W-1:0]          rd_tag,
    output logic [MAX_WAYS-1:0][((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] rd_age
);
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int AGE_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic [MAX_WAYS-1:0]                 valid_mem [NUM_SETS];
    logic [MAX_WAYS-1:0][ADDR_W-1:0]     tag_mem   [NUM_SETS];
    logic [MAX_WAYS-1:0][AGE_W-1:0]      age_mem   [NUM_SETS];
    logic [NUM_SETS-1:0]                 live_reg;
    logic                                rd_live_reg;
    logic [MAX_WAYS-1:0]                 rd_valid_reg;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]     rd_tag_reg;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      rd_age_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            valid_mem[wr_addr] <= wr_valid;
            tag_mem[wr_addr]   <= wr_tag;
            age_mem[wr_addr]   <= wr_age;
        end
        if (rd_en) begin
            rd_valid_reg <= valid_mem[rd_addr];
            rd_tag_reg   <= tag_mem[rd_addr];
            rd_age_reg   <= age_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg    <= '0;
            rd_live_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                live_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_live_reg <= live_reg[rd_addr];
            end
        end
    end

    // A row never written since reset reads as empty with zero ages
    assign rd_valid = rd_live_reg ? rd_valid_reg : '0;
    assign rd_age   = rd_live_reg ? rd_age_reg : '0;
    assign rd_tag   = rd_tag_reg;

endmodule

// File: sv/sal_way_unit.sv
// Shared way compare unit: takes one way per cycle and keeps the first hit,
// the first free way and the oldest way of the set. Depends on sal_pkg.
module sal_way_unit import sal_pkg::*; #(
    parameter int MAX_WAYS = DEF_MAX_WAYS
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            start,
    input  logic                                            step,
    input  logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] step_way,
    input  logic                                            step_valid,
    input  logic [ADDR_W-1:0]                               step_tag,
    input  logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] step_age,
    input  logic [ADDR_W-1:0]                               key_tag,
    output sal_pick_t                                       pick,
    output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] pick_way,
    output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] pick_age
);
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic             hit_reg;
    logic [WAY_W-1:0] hit_way_reg;
    logic [WAY_W-1:0] hit_age_reg;
    logic             free_reg;
    logic [WAY_W-1:0] free_way_reg;
    logic [WAY_W-1:0] best_way_reg;
    logic [WAY_W-1:0] best_age_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || start) begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end else if (step) begin
            if (step_valid && step_tag == key_tag && !hit_reg) begin
                hit_reg     <= 1'b1;
                hit_way_reg <= step_way;
                hit_age_reg <= step_age;
            end
            if (!step_valid && !free_reg) begin
                free_reg     <= 1'b1;
                free_way_reg <= step_way;
            end
        end
    end

    // Oldest way; ties keep the lowest index
    always_ff @(posedge aclk) begin
        if (step && (step_way == '0 || step_age > best_age_reg)) begin
            best_way_reg <= step_way;
            best_age_reg <= step_age;
        end
    end

    assign pick.hit      = hit_reg;
    assign pick.evict    = !hit_reg && !free_reg;
    assign pick.no_limit = !hit_reg && free_reg;
    assign pick_way = hit_reg ? hit_way_reg : (free_reg ? free_way_reg : best_way_reg);
    assign pick_age = hit_reg ? hit_age_reg : best_age_reg;

endmodule

// File: sv/set_assoc_lru_cache_sim.sv
// Set-associative cache model with LRU replacement: sequencer, counters, top level.
// Depends on sal_pkg, sal_row_mem and sal_way_unit.
//
// Each request on s_ is a load, store, modify (two accesses) or ignored fetch of a
// 32-bit address; every access returns one transaction on m_ with hit and eviction
// flags and saturating hit, miss and eviction totals; tlast marks the final one of
// a request. The block takes one request at a time. An access reads the set row,
// passes each of the N effective ways in use through the shared tag compare unit
// in turn, then writes the row back and posts the result; a modify runs two such
// accesses, and an ignored fetch is accepted and dropped without a result. The
// write-back waits while an earlier result is still held on m_. Reset empties the
// cache at once through per-set live flags; there is no clearing pass.
// Configuration is written on cfg_ while idle, a rule for the user that the block
// itself does not enforce; the cache contents survive a change.
module set_assoc_lru_cache_sim import sal_pkg::*; #(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [ADDR_W-1:0]     s_tdata,   // [31:0] address
    input  logic [1:0]            s_tuser,   // [1:0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [0] hit, [1] evicted, [33:2] hit_total,
                                             // [65:34] miss_total, [97:66] eviction_total
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_wdata
);
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int SB_W  = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
    localparam int SH_W  = $clog2(MAX_SET_BITS + 32);
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W  = $clog2(MAX_WAYS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [2:0]          set_bits_reg, set_bits_next;
    logic [4:0]          offset_bits_reg, offset_bits_next;
    logic [3:0]          ways_reg, ways_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                second_reg, second_next;
    logic [ADDR_W-1:0]   tag_reg, tag_next;
    logic [SET_W-1:0]    set_reg, set_next;
    logic [NW_W-1:0]     nways_reg, nways_next;
    logic [WAY_W-1:0]    way_cnt_reg, way_cnt_next;
    logic [CNT_W-1:0]    hits_reg, hits_next;
    logic [CNT_W-1:0]    misses_reg, misses_next;
    logic [CNT_W-1:0]    evicts_reg, evicts_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                hit_o_reg, hit_o_next;
    logic                evict_o_reg, evict_o_next;
    logic                last_o_reg, last_o_next;

    logic [SB_W-1:0]     sb_eff;
    logic [SH_W-1:0]     shift_amt;
    logic [SET_W-1:0]    set_mask;
    logic [ADDR_W-1:0]   tag_calc;
    logic [SET_W-1:0]    set_calc;
    logic [NW_W-1:0]     nways_calc;
    logic                out_free;
    logic                commit;
    logic                rd_en;
    logic                unit_start;
    logic                unit_step;
    logic                scan_done;

    logic [MAX_WAYS-1:0]              rd_valid;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]  rd_tag;
    logic [MAX_WAYS-1:0][WAY_W-1:0]   rd_age;
    logic [MAX_WAYS-1:0]              wr_valid;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]  wr_tag;
    logic [MAX_WAYS-1:0][WAY_W-1:0]   wr_age;

    sal_pick_t           pick;
    logic [WAY_W-1:0]    pick_way;
    logic [WAY_W-1:0]    pick_age;

    sal_row_mem #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_row_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (set_calc),
        .wr_en    (commit),
        .wr_addr  (set_reg),
        .wr_valid (wr_valid),
        .wr_tag   (wr_tag),
        .wr_age   (wr_age),
        .rd_valid (rd_valid),
        .rd_tag   (rd_tag),
        .rd_age   (rd_age)
    );

    sal_way_unit #(
        .MAX_WAYS (MAX_WAYS)
    ) u_way_unit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (unit_start),
        .step       (unit_step),
        .step_way   (way_cnt_reg),
        .step_valid (rd_valid[way_cnt_reg]),
        .step_tag   (rd_tag[way_cnt_reg]),
        .step_age   (rd_age[way_cnt_reg]),
        .key_tag    (tag_reg),
        .pick       (pick),
        .pick_way   (pick_way),
        .pick_age   (pick_age)
    );

    // Address split under the clamped configuration
    always_comb begin
        sb_eff = (set_bits_reg > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : SB_W'(set_bits_reg);
        shift_amt = SH_W'(sb_eff) + SH_W'(offset_bits_reg);
        tag_calc  = addr_reg >> shift_amt;
        set_mask  = ~({SET_W{1'b1}} << sb_eff);
        set_calc  = SET_W'(addr_reg >> offset_bits_reg) & set_mask;
        if (ways_reg == 4'd0) begin
            nways_calc = NW_W'(1);
        end else if (ways_reg > MAX_WAYS) begin
            nways_calc = NW_W'(MAX_WAYS);
        end else begin
            nways_calc = NW_W'(ways_reg);
        end
    end

    // New row: install the tag at the picked way, refresh recency
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            wr_valid[i] = rd_valid[i];
            wr_tag[i]   = rd_tag[i];
            wr_age[i]   = rd_age[i];
            if (WAY_W'(i) == pick_way) begin
                wr_valid[i] = 1'b1;
                wr_tag[i]   = tag_reg;
                wr_age[i]   = '0;
            end else if (NW_W'(i) < nways_reg && rd_valid[i]
                         && (pick.no_limit || rd_age[i] < pick_age)
                         && rd_age[i] < WAY_W'(MAX_WAYS - 1)) begin
                wr_age[i] = rd_age[i] + WAY_W'(1);
            end
        end
    end

    assign out_free   = !m_tvalid_reg || m_tready;
    assign commit     = (state_reg == ST_COMMIT) && out_free;
    assign rd_en      = (state_reg == ST_READ);
    assign unit_start = (state_reg == ST_READ);
    assign unit_step  = (state_reg == ST_SCAN);
    assign scan_done  = (NW_W'(way_cnt_reg) + NW_W'(1)) == nways_reg;

    always_comb begin
        state_next       = state_reg;
        set_bits_next    = set_bits_reg;
        offset_bits_next = offset_bits_reg;
        ways_next        = ways_reg;
        addr_next        = addr_reg;
        second_next      = second_reg;
        tag_next         = tag_reg;
        set_next         = set_reg;
        nways_next       = nways_reg;
        way_cnt_next     = way_cnt_reg;
        hits_next        = hits_reg;
        misses_next      = misses_reg;
        evicts_next      = evicts_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        hit_o_next       = hit_o_reg;
        evict_o_next     = evict_o_reg;
        last_o_next      = last_o_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_SET_BITS:    set_bits_next    = cfg_wdata[2:0];
                CFG_OFFSET_BITS: offset_bits_next = cfg_wdata;
                CFG_WAYS:        ways_next        = cfg_wdata[3:0];
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser != REQ_IGNORE) begin
                    addr_next   = s_tdata;
                    second_next = (s_tuser == REQ_MODIFY);
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                tag_next     = tag_calc;
                set_next     = set_calc;
                nways_next   = nways_calc;
                way_cnt_next = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_COMMIT;
                end else begin
                    way_cnt_next = way_cnt_reg + WAY_W'(1);
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    if (pick.hit) begin
                        hits_next = sat_inc(hits_reg);
                    end else begin
                        misses_next = sat_inc(misses_reg);
                    end
                    if (pick.evict) begin
                        evicts_next = sat_inc(evicts_reg);
                    end
                    m_tvalid_next = 1'b1;
                    hit_o_next    = pick.hit;
                    evict_o_next  = pick.evict;
                    last_o_next   = !second_reg;
                    // A modify runs the same access once more
                    if (second_reg) begin
                        second_next = 1'b0;
                        state_next  = ST_READ;
                    end else begin
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            set_bits_reg    <= 3'd0;
            offset_bits_reg <= 5'd0;
            ways_reg        <= 4'd1;
            second_reg      <= 1'b0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            evicts_reg      <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            set_bits_reg    <= set_bits_next;
            offset_bits_reg <= offset_bits_next;
            ways_reg        <= ways_next;
            second_reg      <= second_next;
            hits_reg        <= hits_next;
            misses_reg      <= misses_next;
            evicts_reg      <= evicts_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        addr_reg    <= addr_next;
        tag_reg     <= tag_next;
        set_reg     <= set_next;
        nways_reg   <= nways_next;
        way_cnt_reg <= way_cnt_next;
        hit_o_reg   <= hit_o_next;
        evict_o_reg <= evict_o_next;
        last_o_reg  <= last_o_next;
    end

    // Totals change only together with a new result, so they feed m_tdata directly
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_o_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, evicts_reg, misses_reg, hits_reg,
                       evict_o_reg, hit_o_reg};

`ifndef SYNTH
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (NW_W'(way_cnt_reg) < nways_reg))
        else $error("way scan ran past the ways in use");

    a_hit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && pick.hit && hits_reg != {CNT_W{1'b1}})
        |=> (hits_reg == $past(hits_reg) + CNT_W'(1)))
        else $error("hit total did not advance on a hit");

    a_modify_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && second_reg) |=> (state_reg == ST_READ && !m_tlast && m_tvalid))
        else $error("modify did not start its second access");
`endif

endmodule
